/* hw/rtl/kmeq_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// kmeq_pkg
// Shared types, codes and character tables of the key matrix event queue.
// -----------------------------------------------------------------------------
package kmeq_pkg;

   localparam int KEY_COUNT = 88;
   localparam int CODE_W    = 7;
   localparam int MODS_W    = 5;
   localparam int EVENT_W   = 21;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_POLL  = 2'd1;
   localparam logic [1:0] OP_GET   = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   localparam logic [2:0] CSR_LSHIFT  = 3'd0;
   localparam logic [2:0] CSR_RSHIFT  = 3'd1;
   localparam logic [2:0] CSR_CONTROL = 3'd2;
   localparam logic [2:0] CSR_CBM     = 3'd3;
   localparam logic [2:0] CSR_ALT     = 3'd4;

   localparam logic [4:0] MOD_SHIFT   = 5'd1;
   localparam logic [4:0] MOD_CONTROL = 5'd2;
   localparam logic [4:0] MOD_CBM     = 5'd4;
   localparam logic [4:0] MOD_ALT     = 5'd8;
   localparam logic [4:0] MOD_CAPS    = 5'd16;

   localparam logic [7:0] LETTER_LO = 8'h61;
   localparam logic [7:0] LETTER_HI = 8'h7A;
   localparam logic [7:0] CTRL_MASK = 8'h1F;

   typedef struct packed {
      logic [MODS_W-1:0] mods;
      logic [7:0]        chr;
      logic [CODE_W-1:0] scan;
      logic              kind;
   } event_type;

   typedef struct packed {
      logic start;
      logic push;
      logic pop;
      logic kind;
   } qctl_type;

   function automatic logic [7:0] plain_char(input logic [CODE_W-1:0] c);
      logic [7:0] r;
      case (c)
         7'd0: r = 8'd8;    7'd1: r = 8'd10;
         7'd8: r = "3";     7'd9: r = "w";    7'd10: r = "a";  7'd11: r = "4";
         7'd12: r = "z";    7'd13: r = "s";   7'd14: r = "e";
         7'd16: r = "5";    7'd17: r = "r";   7'd18: r = "d";  7'd19: r = "6";
         7'd20: r = "c";    7'd21: r = "f";   7'd22: r = "t";  7'd23: r = "x";
         7'd24: r = "7";    7'd25: r = "y";   7'd26: r = "g";  7'd27: r = "8";
         7'd28: r = "b";    7'd29: r = "h";   7'd30: r = "u";  7'd31: r = "v";
         7'd32: r = "9";    7'd33: r = "i";   7'd34: r = "j";  7'd35: r = "0";
         7'd36: r = "m";    7'd37: r = "k";   7'd38: r = "o";  7'd39: r = "n";
         7'd40: r = "+";    7'd41: r = "p";   7'd42: r = "l";  7'd43: r = "-";
         7'd44: r = ".";    7'd45: r = ":";   7'd46: r = "@";  7'd47: r = ",";
         7'd49: r = "*";    7'd50: r = ";";   7'd53: r = "=";  7'd55: r = "/";
         7'd56: r = "1";    7'd59: r = "2";   7'd60: r = " ";  7'd62: r = "q";
         7'd65: r = "8";    7'd66: r = "5";   7'd67: r = 8'd9; 7'd68: r = "2";
         7'd69: r = "4";    7'd70: r = "7";   7'd71: r = "1";
         7'd72: r = 8'h1B;  7'd73: r = "+";   7'd74: r = "-";  7'd75: r = 8'd10;
         7'd76: r = 8'd10;  7'd77: r = "6";   7'd78: r = "9";  7'd79: r = "3";
         7'd81: r = "0";    7'd82: r = ".";
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] upper_char(input logic [CODE_W-1:0] c);
      logic [7:0] r;
      case (c)
         7'd8: r = "#";     7'd9: r = "W";    7'd10: r = "A";  7'd11: r = "$";
         7'd12: r = "Z";    7'd13: r = "S";   7'd14: r = "E";
         7'd16: r = "%";    7'd17: r = "R";   7'd18: r = "D";  7'd19: r = "&";
         7'd20: r = "C";    7'd21: r = "F";   7'd22: r = "T";  7'd23: r = "X";
         7'd24: r = 8'd39;  7'd25: r = "Y";   7'd26: r = "G";  7'd27: r = "(";
         7'd28: r = "B";    7'd29: r = "H";   7'd30: r = "U";  7'd31: r = "V";
         7'd32: r = ")";    7'd33: r = "I";   7'd34: r = "J";
         7'd36: r = "M";    7'd37: r = "K";   7'd38: r = "O";  7'd39: r = "N";
         7'd41: r = "P";    7'd42: r = "L";
         7'd44: r = ">";    7'd45: r = "[";   7'd47: r = "<";
         7'd50: r = "]";    7'd55: r = "?";
         7'd56: r = "!";    7'd59: r = 8'h22; 7'd62: r = "Q";
         default: r = plain_char(c);
      endcase
      return r;
   endfunction

endpackage

/* hw/rtl/kmeq_ram.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// kmeq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// -----------------------------------------------------------------------------
module kmeq_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* hw/rtl/kmeq_queue.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// kmeq_queue
// Event FIFO with drop and event counters.
// -----------------------------------------------------------------------------
module kmeq_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  kmeq_pkg::qctl_type           ctl,
   input  logic [kmeq_pkg::EVENT_W-1:0] wr_data,
   output logic [kmeq_pkg::EVENT_W-1:0] rd_data,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] level,
   output logic                         empty,
   output logic [7:0]                   drops,
   output logic [15:0]                  presses,
   output logic [15:0]                  releases
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int LW = $clog2(QUEUE_DEPTH + 1);

   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [7:0]    drop_ff, drop_in;
   logic [15:0]   pr_ff, pr_in, rl_ff, rl_in;
   logic          full, wr_en;

   assign full  = (lvl_ff == LW'(QUEUE_DEPTH));
   assign empty = (lvl_ff == '0);
   assign wr_en = ctl.push && !full;

   always_comb begin
      wp_in = wp_ff; rp_in = rp_ff; lvl_in = lvl_ff;
      drop_in = drop_ff; pr_in = pr_ff; rl_in = rl_ff;
      if (ctl.start) begin
         wp_in = '0; rp_in = '0; lvl_in = '0;
         drop_in = '0; pr_in = '0; rl_in = '0;
      end else if (ctl.push) begin
         if (full) begin
            drop_in = drop_ff + 8'd1;
         end else begin
            wp_in  = (wp_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + AW'(1);
            lvl_in = lvl_ff + LW'(1);
            if (ctl.kind) pr_in = pr_ff + 16'd1;
            else          rl_in = rl_ff + 16'd1;
         end
      end else if (ctl.pop && !empty) begin
         rp_in  = (rp_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + AW'(1);
         lvl_in = lvl_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; lvl_ff <= '0;
         drop_ff <= '0; pr_ff <= '0; rl_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; lvl_ff <= lvl_in;
         drop_ff <= drop_in; pr_ff <= pr_in; rl_ff <= rl_in;
      end
   end

   kmeq_ram #(.WIDTH(kmeq_pkg::EVENT_W), .DEPTH(QUEUE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_addr (rp_ff),
      .rd_data (rd_data)
   );

   assign level    = lvl_ff;
   assign drops    = drop_ff;
   assign presses  = pr_ff;
   assign releases = rl_ff;

endmodule

/* hw/rtl/key_matrix_event_queue.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// key_matrix_event_queue
// Keyboard matrix scanner: compares snapshots and queues key events.
// -----------------------------------------------------------------------------
// Poll: the request is latched, then the key bits are stepped (MATRIX_LINES*8 steps
//   through one compare/encode unit), then the response is registered.
// Start skips the scan; get adds a queue read state (registered RAM read). One item
//   at a time: the next item can be taken in the cycle after the response leaves.
// Synchronous active-high reset clears the reference, queue and counters.
// -----------------------------------------------------------------------------
module key_matrix_event_queue #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int MATRIX_LINES = 11
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // op[1:0], matrix_low[65:2], matrix_high[89:66], caps_lock[90], zero fill
   input  logic [95:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[0], event_type[1], event_scan[8:2], event_char[16:9],
   // event_mods[21:17], queue_level[26:22], dropped_count[34:27],
   // press_count[50:35], release_count[66:51], poll_count[82:67], zero fill
   output logic [87:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [6:0]   csr_wdata
);

   localparam int NKEYS = MATRIX_LINES * 8;
   localparam int KW    = $clog2(NKEYS);
   localparam int LW    = $clog2(QUEUE_DEPTH + 1);
   localparam logic [87:0] KEY_MASK = {88{1'b1}} >> (88 - NKEYS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_DATA = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0]   state_ff, state_in;
   logic [6:0]   lsh_ff, rsh_ff, ctl_ff, cbm_ff, alt_ff;
   logic [87:0]  ref_ff, ref_in;
   logic [87:0]  now_ff;
   logic [4:0]   mods_ff, mods_in;
   logic [KW-1:0] key_ff, key_in;
   logic [1:0]   op_ff;
   logic [87:0]  rsp_ff, rsp_in;
   logic         pop_ok_ff, pop_ok_in;
   logic [15:0]  poll_ff, poll_in;

   logic [87:0]  req_keys;
   logic [1:0]   req_op;
   logic         accept, rsp_fire;
   logic         diff_bit, now_bit, is_letter, sh;
   logic         shift_on, caps_on, ctrl_on;
   logic [6:0]   code;
   logic [7:0]   pch, chr;
   kmeq_pkg::event_type ev, pop_ev;
   kmeq_pkg::qctl_type  qctl;
   logic [kmeq_pkg::EVENT_W-1:0] q_rd;
   logic [LW-1:0] q_level;
   logic          q_empty;
   logic [7:0]    q_drops;
   logic [15:0]   q_pr, q_rl;

   assign req_op   = req_tdata[1:0];
   assign req_keys = req_tdata[89:2] & KEY_MASK;
   assign accept   = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = rsp_ff;

   function automatic logic held(input logic [87:0] k, input logic [6:0] c);
      return (c < 7'(NKEYS)) ? k[c] : 1'b0;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         lsh_ff <= 7'd15; rsh_ff <= 7'd52; ctl_ff <= 7'd58;
         cbm_ff <= 7'd61; alt_ff <= 7'd80;
      end else if (csr_we) begin
         unique case (csr_index)
            kmeq_pkg::CSR_LSHIFT:  lsh_ff <= csr_wdata;
            kmeq_pkg::CSR_RSHIFT:  rsh_ff <= csr_wdata;
            kmeq_pkg::CSR_CONTROL: ctl_ff <= csr_wdata;
            kmeq_pkg::CSR_CBM:     cbm_ff <= csr_wdata;
            kmeq_pkg::CSR_ALT:     alt_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shared compare/encode unit, one key per cycle
   assign code     = 7'(key_ff);
   assign diff_bit = now_ff[key_ff] ^ ref_ff[key_ff];
   assign now_bit  = now_ff[key_ff];
   assign pch      = kmeq_pkg::plain_char(code);
   assign is_letter = (pch >= kmeq_pkg::LETTER_LO) && (pch <= kmeq_pkg::LETTER_HI);
   assign shift_on = |(mods_ff & kmeq_pkg::MOD_SHIFT);
   assign caps_on  = |(mods_ff & kmeq_pkg::MOD_CAPS);
   assign ctrl_on  = |(mods_ff & kmeq_pkg::MOD_CONTROL);
   assign sh = is_letter ? (shift_on ^ caps_on) : shift_on;

   always_comb begin
      chr = sh ? kmeq_pkg::upper_char(code) : pch;
      if (is_letter && ctrl_on) chr = chr & kmeq_pkg::CTRL_MASK;
      ev.kind = now_bit;
      ev.scan = code;
      ev.chr  = chr;
      ev.mods = mods_ff;
   end

   assign pop_ev = kmeq_pkg::event_type'(q_rd);

   always_comb begin
      state_in = state_ff; ref_in = ref_ff; mods_in = mods_ff; key_in = key_ff;
      rsp_in = rsp_ff; pop_ok_in = pop_ok_ff; poll_in = poll_ff;
      qctl = '0;
      qctl.kind = now_bit;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mods_in = '0;
               if (held(req_keys, lsh_ff) || held(req_keys, rsh_ff))
                  mods_in = mods_in | kmeq_pkg::MOD_SHIFT;
               if (held(req_keys, ctl_ff)) mods_in = mods_in | kmeq_pkg::MOD_CONTROL;
               if (held(req_keys, cbm_ff)) mods_in = mods_in | kmeq_pkg::MOD_CBM;
               if (held(req_keys, alt_ff)) mods_in = mods_in | kmeq_pkg::MOD_ALT;
               if (req_tdata[90]) mods_in = mods_in | kmeq_pkg::MOD_CAPS;
               key_in = '0;
               if (req_op == kmeq_pkg::OP_START) begin
                  ref_in = req_keys; poll_in = '0; qctl.start = 1'b1;
                  state_in = S_DATA;
               end else if (req_op == kmeq_pkg::OP_POLL) begin
                  state_in = S_SCAN;
               end else if (req_op == kmeq_pkg::OP_GET) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_DATA;
               end
            end
         end
         S_SCAN: begin
            qctl.push = diff_bit;
            if (key_ff == KW'(NKEYS - 1)) begin
               ref_in = now_ff; poll_in = poll_ff + 16'd1; state_in = S_DATA;
            end else begin
               key_in = key_ff + KW'(1);
            end
         end
         S_READ: begin
            pop_ok_in = !q_empty;
            qctl.pop  = 1'b1;
            state_in  = S_DATA;
         end
         S_DATA: begin
            rsp_in = '0;
            if (op_ff == kmeq_pkg::OP_GET) begin
               if (pop_ok_ff) begin
                  rsp_in[1]     = pop_ev.kind;
                  rsp_in[8:2]   = pop_ev.scan;
                  rsp_in[16:9]  = pop_ev.chr;
                  rsp_in[21:17] = pop_ev.mods;
               end else begin
                  rsp_in[0] = 1'b1;
               end
            end
            rsp_in[26:22] = 5'(q_level);
            rsp_in[34:27] = q_drops;
            rsp_in[50:35] = q_pr;
            rsp_in[66:51] = q_rl;
            rsp_in[82:67] = poll_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_fire) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ref_ff <= '0; poll_ff <= '0; pop_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ref_ff <= ref_in; poll_ff <= poll_in;
         pop_ok_ff <= pop_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      mods_ff <= mods_in;
      key_ff  <= key_in;
      rsp_ff  <= rsp_in;
      if (accept) begin
         now_ff <= req_keys;
         op_ff  <= req_op;
      end
   end

   kmeq_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctl      (qctl),
      .wr_data  (ev),
      .rd_data  (q_rd),
      .level    (q_level),
      .empty    (q_empty),
      .drops    (q_drops),
      .presses  (q_pr),
      .releases (q_rl)
   );

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("accepted item while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");
   a_level_max: assert property (@(posedge clock) disable iff (reset)
      q_level <= LW'(QUEUE_DEPTH))
      else $error("queue level overflow");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Testbench of the key matrix event queue. A directed table covers start,
// poll and get on empty, full and wrapped queues, the modifier keys, caps and
// control on letters and non-letters, and the unknown operation. A random
// part follows: start/poll/get sequences with random and sparse matrices.
// A local predictor produces one expected response per request; each
// response is compared field by field. Both sides idle at random, and the
// receiver holds off once for a long stretch.
// -----------------------------------------------------------------------------
module tb_top;

   localparam int DEPTH = 16;
   localparam int LINES = 11;
   localparam int N_RANDOM = 1600;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] mlow;
      logic [23:0] mhigh;
      logic        caps;
   } key_req_type;

   // lowest field last, matching the response bus layout
   typedef struct packed {
      logic [15:0] polls;
      logic [15:0] releases;
      logic [15:0] presses;
      logic [7:0]  dropped;
      logic [4:0]  level;
      logic [4:0]  mods;
      logic [7:0]  chr;
      logic [6:0]  scan;
      logic        kind;
      logic        status;
   } key_rsp_type;

   typedef struct {
      key_req_type req;
      bit          typed;
      key_rsp_type rsp;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [6:0]  csr_wdata = '0;

   key_matrix_event_queue #(.QUEUE_DEPTH(DEPTH), .MATRIX_LINES(LINES)) u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_index, .csr_wdata
   );

   always #5 clock = ~clock;

   // predictor state
   logic [6:0]  mod_code [5];
   logic [87:0] ref_keys;
   logic [20:0] ev_store [DEPTH];
   int          wr_ptr, rd_ptr, ev_level;
   logic [7:0]  drop_cnt;
   logic [15:0] press_cnt, release_cnt, poll_cnt;

   key_rsp_type expected_rsps[$];
   int  errors = 0;
   int  checked = 0;
   int  cycles = 0;
   bit  quiet = 0;
   bit  hold_rsp = 0;
   int  n_drops = 0;
   int  rsp_idle = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch #%0d %s: got %0h want %0h", checked, what, got, want);
   endtask

   function automatic bit key_held(logic [87:0] keys, logic [6:0] code);
      if (code >= kmeq_pkg::KEY_COUNT) return 0;
      return keys[code];
   endfunction

   function automatic logic [87:0] rand_keys();
      return 88'({$urandom, $urandom, $urandom});
   endfunction

   function automatic logic [7:0] char_of(logic [6:0] code, logic [4:0] mods);
      logic [7:0] lower, upper, c;
      bit sh;
      lower = 8'd0;
      upper = 8'd0;
      sh = |(mods & kmeq_pkg::MOD_SHIFT);
      case (code)
         0: lower = 8'd8; 1: lower = 8'd10;
         8: begin lower = "3"; upper = "#"; end
         9: lower = "w"; 10: lower = "a";
         11: begin lower = "4"; upper = "$"; end
         12: lower = "z"; 13: lower = "s"; 14: lower = "e";
         16: begin lower = "5"; upper = "%"; end
         17: lower = "r"; 18: lower = "d";
         19: begin lower = "6"; upper = "&"; end
         20: lower = "c"; 21: lower = "f"; 22: lower = "t"; 23: lower = "x";
         24: begin lower = "7"; upper = 8'd39; end
         25: lower = "y"; 26: lower = "g";
         27: begin lower = "8"; upper = "("; end
         28: lower = "b"; 29: lower = "h"; 30: lower = "u"; 31: lower = "v";
         32: begin lower = "9"; upper = ")"; end
         33: lower = "i"; 34: lower = "j"; 35: lower = "0";
         36: lower = "m"; 37: lower = "k"; 38: lower = "o"; 39: lower = "n";
         40: lower = "+"; 41: lower = "p"; 42: lower = "l"; 43: lower = "-";
         44: begin lower = "."; upper = ">"; end
         45: begin lower = ":"; upper = "["; end
         46: lower = "@";
         47: begin lower = ","; upper = "<"; end
         49: lower = "*";
         50: begin lower = ";"; upper = "]"; end
         53: lower = "=";
         55: begin lower = "/"; upper = "?"; end
         56: begin lower = "1"; upper = "!"; end
         59: begin lower = "2"; upper = 8'h22; end
         60: lower = " "; 62: lower = "q";
         65: lower = "8"; 66: lower = "5"; 67: lower = 8'd9; 68: lower = "2";
         69: lower = "4"; 70: lower = "7"; 71: lower = "1";
         72: lower = 8'h1B; 73: lower = "+"; 74: lower = "-"; 75: lower = 8'd10;
         76: lower = 8'd10; 77: lower = "6"; 78: lower = "9"; 79: lower = "3";
         81: lower = "0"; 82: lower = ".";
         default: lower = 8'd0;
      endcase
      if (lower >= "a" && lower <= "z") begin
         upper = lower - 8'd32;
         if (|(mods & kmeq_pkg::MOD_CAPS)) sh = !sh;
         c = sh ? upper : lower;
         if (|(mods & kmeq_pkg::MOD_CONTROL)) c = c & 8'h1F;
      end else begin
         if (upper == 8'd0) upper = lower;
         c = sh ? upper : lower;
      end
      return c;
   endfunction

   function automatic key_rsp_type predict_scan(key_req_type r);
      key_rsp_type o;
      logic [87:0] now;
      logic [4:0] mods;
      logic [20:0] e;
      o = '0;
      now = {r.mhigh, r.mlow};
      case (r.op)
         kmeq_pkg::OP_START: begin
            ref_keys = now;
            wr_ptr = 0; rd_ptr = 0; ev_level = 0;
            drop_cnt = '0; press_cnt = '0; release_cnt = '0; poll_cnt = '0;
         end
         kmeq_pkg::OP_POLL: begin
            mods = '0;
            if (key_held(now, mod_code[kmeq_pkg::CSR_LSHIFT]) ||
                key_held(now, mod_code[kmeq_pkg::CSR_RSHIFT]))
               mods |= kmeq_pkg::MOD_SHIFT;
            if (key_held(now, mod_code[kmeq_pkg::CSR_CONTROL]))
               mods |= kmeq_pkg::MOD_CONTROL;
            if (key_held(now, mod_code[kmeq_pkg::CSR_CBM])) mods |= kmeq_pkg::MOD_CBM;
            if (key_held(now, mod_code[kmeq_pkg::CSR_ALT])) mods |= kmeq_pkg::MOD_ALT;
            if (r.caps) mods |= kmeq_pkg::MOD_CAPS;
            for (int k = 0; k < kmeq_pkg::KEY_COUNT; k++) begin
               if (now[k] != ref_keys[k]) begin
                  if (ev_level >= DEPTH) begin
                     drop_cnt++;
                     n_drops++;
                  end else begin
                     e = {mods, char_of(k[6:0], mods), k[6:0], now[k]};
                     ev_store[wr_ptr] = e;
                     wr_ptr = (wr_ptr + 1) % DEPTH;
                     ev_level++;
                     if (now[k]) press_cnt++;
                     else release_cnt++;
                  end
               end
            end
            ref_keys = now;
            poll_cnt++;
         end
         kmeq_pkg::OP_GET: begin
            if (ev_level == 0) o.status = 1'b1;
            else begin
               e = ev_store[rd_ptr];
               rd_ptr = (rd_ptr + 1) % DEPTH;
               ev_level--;
               {o.mods, o.chr, o.scan, o.kind} = e;
            end
         end
         default: ;
      endcase
      o.level = ev_level[4:0];
      o.dropped = drop_cnt;
      o.presses = press_cnt;
      o.releases = release_cnt;
      o.polls = poll_cnt;
      return o;
   endfunction

   // valid stays up after the handshake until the next item or an idle gap
   task automatic send_item(key_req_type r);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 3);
         repeat (gap) @(negedge clock);
      end
      expected_rsps.push_back(predict_scan(r));
      req_tdata <= {5'd0, r.caps, r.mhigh, r.mlow, r.op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [6:0] val);
      req_tvalid <= 1'b0;
      wait (expected_rsps.size() == 0);
      repeat (100) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      mod_code[idx] = val;
   endtask

   function automatic key_req_type mk(logic [1:0] op, logic [87:0] keys, logic caps);
      key_req_type r;
      r.op = op;
      {r.mhigh, r.mlow} = keys;
      r.caps = caps;
      return r;
   endfunction

   // receiver
   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_tready <= 1'b0;
      else if (rsp_idle > 0) begin
         rsp_tready <= 1'b0;
         rsp_idle--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         rsp_idle = $urandom_range(0, 2);
      end else rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin
      key_rsp_type got, want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[82:0];
         checked++;
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("unexpected response %h", rsp_tdata);
         end else begin
            want = expected_rsps.pop_front();
            if (got.status !== want.status)
               report("status", 32'(got.status), 32'(want.status));
            if (got.kind !== want.kind)
               report("event_type", 32'(got.kind), 32'(want.kind));
            if (got.scan !== want.scan)
               report("event_scan", 32'(got.scan), 32'(want.scan));
            if (got.chr !== want.chr)
               report("event_char", 32'(got.chr), 32'(want.chr));
            if (got.mods !== want.mods)
               report("event_mods", 32'(got.mods), 32'(want.mods));
            if (got.level !== want.level)
               report("queue_level", 32'(got.level), 32'(want.level));
            if (got.dropped !== want.dropped)
               report("dropped", 32'(got.dropped), 32'(want.dropped));
            if (got.presses !== want.presses)
               report("press", 32'(got.presses), 32'(want.presses));
            if (got.releases !== want.releases)
               report("release", 32'(got.releases), 32'(want.releases));
            if (got.polls !== want.polls)
               report("poll", 32'(got.polls), 32'(want.polls));
         end
      end
   end

   initial begin
      table_row_type rows[$];
      table_row_type row;
      key_req_type r;
      logic [87:0] keys, all_keys;
      int n, wait_cycles;

      mod_code[kmeq_pkg::CSR_LSHIFT] = 7'd15;
      mod_code[kmeq_pkg::CSR_RSHIFT] = 7'd52;
      mod_code[kmeq_pkg::CSR_CONTROL] = 7'd58;
      mod_code[kmeq_pkg::CSR_CBM] = 7'd61;
      mod_code[kmeq_pkg::CSR_ALT] = 7'd80;
      ref_keys = '0;
      wr_ptr = 0; rd_ptr = 0; ev_level = 0;
      drop_cnt = '0; press_cnt = '0; release_cnt = '0; poll_cnt = '0;
      all_keys = '1;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed table
      row.typed = 1'b1; row.req = mk(kmeq_pkg::OP_GET, '0, 1'b0);
      row.rsp = '0; row.rsp.status = 1'b1;
      rows.push_back(row);
      row.typed = 1'b1; row.req = mk(kmeq_pkg::OP_NOP, all_keys, 1'b1);
      row.rsp = '0; rows.push_back(row);
      row.typed = 1'b1; row.req = mk(kmeq_pkg::OP_START, all_keys, 1'b0);
      row.rsp = '0; rows.push_back(row);
      row.typed = 1'b0;
      row.req = mk(kmeq_pkg::OP_POLL, '0, 1'b0); rows.push_back(row);
      for (int i = 0; i < 3; i++) begin
         row.req = mk(kmeq_pkg::OP_GET, '0, 1'b0); rows.push_back(row);
      end
      row.req = mk(kmeq_pkg::OP_START, '0, 1'b0); rows.push_back(row);
      row.req = mk(kmeq_pkg::OP_POLL, 88'h1 << 10, 1'b0); rows.push_back(row);
      row.req = mk(kmeq_pkg::OP_POLL, (88'h1 << 10) | (88'h1 << 15), 1'b0);
      rows.push_back(row);
      row.req = mk(kmeq_pkg::OP_POLL, (88'h1 << 8) | (88'h1 << 52) | (88'h1 << 58), 1'b1);
      rows.push_back(row);
      row.req = mk(kmeq_pkg::OP_POLL,
                   (88'h1 << 12) | (88'h1 << 58) | (88'h1 << 61) | (88'h1 << 80), 1'b1);
      rows.push_back(row);
      row.req = mk(kmeq_pkg::OP_POLL, 88'h1 << 87, 1'b0); rows.push_back(row);
      for (int i = 0; i < 8; i++) begin
         row.req = mk(kmeq_pkg::OP_GET, '0, 1'b0); rows.push_back(row);
      end
      foreach (rows[i]) begin
         send_item(rows[i].req);
         if (rows[i].typed && expected_rsps[$] !== rows[i].rsp) begin
            errors++;
            $display("table row %0d predicts %h", i, expected_rsps[$]);
         end
      end

      // move modifiers to the extremes, including beyond the matrix
      write_csr(kmeq_pkg::CSR_LSHIFT, 7'd0);
      write_csr(kmeq_pkg::CSR_RSHIFT, 7'd127);
      write_csr(kmeq_pkg::CSR_CONTROL, 7'd87);
      write_csr(kmeq_pkg::CSR_CBM, 7'd88);
      write_csr(kmeq_pkg::CSR_ALT, 7'd1);

      // fill the queue under a long receiver hold-off; drops and wrap
      hold_rsp = 1'b1;
      fork
         begin
            wait_cycles = 0;
            while (wait_cycles < 400) begin
               @(negedge clock);
               wait_cycles++;
            end
            hold_rsp = 1'b0;
         end
         begin
            send_item(mk(kmeq_pkg::OP_START, '0, 1'b0));
            send_item(mk(kmeq_pkg::OP_POLL, all_keys, 1'b1));
            send_item(mk(kmeq_pkg::OP_POLL, '0, 1'b0));
            for (int i = 0; i < 20; i++) send_item(mk(kmeq_pkg::OP_GET, '0, 1'b0));
         end
      join

      for (int phase = 0; phase < 4; phase++) begin
         if (phase > 0) begin
            for (int c = 0; c < 5; c++)
               write_csr(c[2:0], (phase == 3) ? 7'(15 + 37 * c) : 7'($urandom_range(0, 127)));
         end
         for (int i = 0; i < N_RANDOM / 4; i++) begin
            quiet = (phase == 3) && (i > N_RANDOM / 8);
            n = $urandom_range(0, 99);
            if (n < 3) r = mk(kmeq_pkg::OP_START, rand_keys(), 1'($urandom));
            else if (n < 5) r = mk(kmeq_pkg::OP_NOP, rand_keys(), 1'($urandom));
            else if (n < 35) begin
               keys = ref_keys;
               if ($urandom_range(0, 5) == 0) keys = rand_keys();
               else
                  repeat ($urandom_range(1, 4)) keys[$urandom_range(0, 87)] ^= 1'b1;
               for (int c = 0; c < 5; c++)
                  if (mod_code[c] < 88 && $urandom_range(0, 1))
                     keys[mod_code[c]] = 1'($urandom);
               r = mk(kmeq_pkg::OP_POLL, keys, 1'($urandom));
            end else r = mk(kmeq_pkg::OP_GET, rand_keys(), 1'($urandom));
            send_item(r);
         end
      end

      req_tvalid <= 1'b0;
      wait (expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d responses, %0d dropped events, modifier codes at extremes",
               checked, n_drops);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/kmeq_pkg.sv
hw/rtl/kmeq_ram.sv
hw/rtl/kmeq_queue.sv
hw/rtl/key_matrix_event_queue.sv
test/tb_top.sv
